// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lattice edge sequencer RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LSEQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LSEQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lseq_pkg.sv =====
// Package for the lattice edge sequencer: widths, register indexes and
// the config / result structs. No dependencies.
package lseq_pkg;

  localparam int SIDE_W     = 9;   // lattice side L, 2..256
  localparam int IDX_W      = 8;   // row / column counters
  localparam int NODE_W     = 16;  // node ids
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [SIDE_W-1:0] MIN_SIDE = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLIC   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED = CFG_IDX_W'(2);

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic              cyclic;
    logic              directed;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic              valid_res;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/lseq_in_if.sv =====
// Request channel of the lattice edge sequencer (valid/ready + restart).
// Depends on nothing.
interface lseq_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ===== rtl/core/lseq_out_if.sv =====
// Result channel of the lattice edge sequencer (valid/ready + edge fields).
// Depends on lseq_pkg.
interface lseq_out_if;
  import lseq_pkg::*;

  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] src_node;
  logic [NODE_W-1:0] dst_node;
  logic              valid_res;
  logic              last;

  modport source (output valid, output src_node, output dst_node, output valid_res,
                  output last, input ready);
  modport sink   (input valid, input src_node, input dst_node, input valid_res,
                  input last, output ready);
endinterface

// ===== rtl/core/lseq_cfg.sv =====
// Configuration registers of the lattice edge sequencer, with side clamp.
// Depends on lseq_pkg.
module lseq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lseq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lseq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lseq_pkg::cfg_t                   cfg,
  output lseq_pkg::cfg_t                   cfg_nxt,
  output logic                             walk_clr
);
  import lseq_pkg::*;

  cfg_t              cfg_r;
  logic [SIDE_W-1:0] side_clamp;

  always_comb begin
    if (cfg_data < MIN_SIDE) begin
      side_clamp = MIN_SIDE;
    end else if (cfg_data > MAX_SIDE) begin
      side_clamp = MAX_SIDE;
    end else begin
      side_clamp = cfg_data;
    end
  end

  always_comb begin
    cfg_nxt  = cfg_r;
    walk_clr = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIDE_LEN: begin
          cfg_nxt.side = side_clamp;
          walk_clr     = 1'b1;
        end
        CFG_CYCLIC: begin
          cfg_nxt.cyclic = cfg_data[0];
          walk_clr       = 1'b1;
        end
        CFG_DIRECTED: begin
          cfg_nxt.directed = cfg_data[0];
          walk_clr         = 1'b1;
        end
        default: walk_clr = 1'b0;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.side     <= MIN_SIDE;
      cfg_r.cyclic   <= 1'b0;
      cfg_r.directed <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/lseq_walk.sv =====
// Edge walk state and node id datapath of the lattice edge sequencer.
// Depends on lseq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lseq_walk (
  input  logic           clk,
  input  logic           rst_n,
  input  lseq_pkg::cfg_t cfg,
  input  lseq_pkg::cfg_t cfg_nxt,
  input  logic           walk_clr,
  input  logic           step,
  input  logic           restart,
  output lseq_pkg::res_t res
);
  import lseq_pkg::*;

  typedef enum logic [1:0] {PH_INTERIOR, PH_BORDER, PH_WRAP} phase_t;

  phase_t            phase_r, phase_nxt, ph_cur;
  logic [IDX_W-1:0]  row_r, row_nxt, row_cur;
  logic [IDX_W-1:0]  col_r, col_nxt, col_cur;
  logic [1:0]        sub_r, sub_nxt, sub_cur;
  logic              fin_r, fin_nxt, fin_cur;
  logic [NODE_W-1:0] base_r, base_nxt, base_cur;  // row_index * L, kept running
  logic [NODE_W-1:0] wrap_r, wrap_nxt;            // (L-1) * L, caught at border end
  logic [NODE_W-1:0] side_n, row_n, col_n, a, b;
  logic [SIDE_W-1:0] row_inc, col_inc;
  logic              row_end, col_end, node_done;

  assign side_n = {{(NODE_W-SIDE_W){1'b0}}, cfg.side};
  assign row_n  = {{(NODE_W-IDX_W){1'b0}}, row_cur};
  assign col_n  = {{(NODE_W-IDX_W){1'b0}}, col_cur};

  // restart takes effect before the current edge is formed
  always_comb begin
    ph_cur   = restart ? PH_INTERIOR : phase_r;
    row_cur  = restart ? IDX_W'(1) : row_r;
    col_cur  = restart ? IDX_W'(1) : col_r;
    sub_cur  = restart ? 2'd0 : sub_r;
    fin_cur  = restart ? 1'b0 : fin_r;
    base_cur = restart ? side_n : base_r;
  end

  assign row_inc   = {1'b0, row_cur} + SIDE_W'(1);
  assign col_inc   = {1'b0, col_cur} + SIDE_W'(1);
  assign row_end   = row_inc >= cfg.side;
  assign col_end   = col_inc >= cfg.side;
  assign node_done = (sub_cur == 2'd3) || (!cfg.directed && sub_cur == 2'd2);

  always_comb begin
    phase_nxt = ph_cur;
    row_nxt   = row_cur;
    col_nxt   = col_cur;
    sub_nxt   = sub_cur;
    fin_nxt   = fin_cur;
    base_nxt  = base_cur;
    wrap_nxt  = wrap_r;
    a         = '0;
    b         = '0;
    res       = '0;

    if (!fin_cur) begin
      unique case (ph_cur)
        PH_INTERIOR: begin
          a = base_cur + col_n;
          b = sub_cur[1] ? a - side_n : a - NODE_W'(1);
        end
        PH_BORDER: begin
          a = sub_cur[1] ? base_cur : row_n;
          b = sub_cur[1] ? base_cur - side_n : row_n - NODE_W'(1);
        end
        PH_WRAP: begin
          a = sub_cur[1] ? base_cur : row_n;
          b = sub_cur[1] ? base_cur + side_n - NODE_W'(1) : row_n + wrap_r;
        end
        default: begin
          a = '0;
          b = '0;
        end
      endcase

      // odd sub-steps carry the reverse edge
      res.src_node  = sub_cur[0] ? b : a;
      res.dst_node  = sub_cur[0] ? a : b;
      res.valid_res = 1'b1;

      if (!node_done) begin
        sub_nxt = cfg.directed ? sub_cur + 2'd1 : 2'd2;
      end else begin
        sub_nxt = 2'd0;
        unique case (ph_cur)
          PH_INTERIOR: begin
            if (!col_end) begin
              col_nxt = col_inc[IDX_W-1:0];
            end else begin
              col_nxt = IDX_W'(1);
              if (!row_end) begin
                row_nxt  = row_inc[IDX_W-1:0];
                base_nxt = base_cur + side_n;
              end else begin
                phase_nxt = PH_BORDER;
                row_nxt   = IDX_W'(1);
                base_nxt  = side_n;
              end
            end
          end
          PH_BORDER: begin
            if (!row_end) begin
              row_nxt  = row_inc[IDX_W-1:0];
              base_nxt = base_cur + side_n;
            end else if (cfg.cyclic && cfg.side != MIN_SIDE) begin
              phase_nxt = PH_WRAP;
              row_nxt   = '0;
              base_nxt  = '0;
              wrap_nxt  = base_cur;  // last row base is (L-1)*L
            end else begin
              fin_nxt = 1'b1;
            end
          end
          PH_WRAP: begin
            if (!row_end) begin
              row_nxt  = row_inc[IDX_W-1:0];
              base_nxt = base_cur + side_n;
            end else begin
              fin_nxt = 1'b1;
            end
          end
          default: fin_nxt = 1'b1;
        endcase
      end
      res.last = fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INTERIOR;
      row_r   <= IDX_W'(1);
      col_r   <= IDX_W'(1);
      sub_r   <= 2'd0;
      fin_r   <= 1'b0;
      base_r  <= NODE_W'(MIN_SIDE);
    end else if (walk_clr) begin
      phase_r <= PH_INTERIOR;
      row_r   <= IDX_W'(1);
      col_r   <= IDX_W'(1);
      sub_r   <= 2'd0;
      fin_r   <= 1'b0;
      base_r  <= {{(NODE_W-SIDE_W){1'b0}}, cfg_nxt.side};
    end else if (step) begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      sub_r   <= sub_nxt;
      fin_r   <= fin_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      wrap_r <= wrap_nxt;
    end
  end

  `LSEQ_ASSERT_NXT(a_last_sets_fin, step && res.last && !walk_clr, fin_r,
    "final edge did not leave the walk finished")
  `LSEQ_ASSERT_IMP(a_rev_only_directed, sub_r[0], cfg.directed,
    "reverse sub-step reached in undirected mode")
  `LSEQ_ASSERT_IMP(a_idx_in_range, !fin_r,
    ({1'b0, row_r} < cfg.side) && ({1'b0, col_r} < cfg.side) && (col_r != '0),
    "row or column counter outside the lattice")

endmodule

// ===== rtl/core/lattice_edge_sequencer.sv =====
// Lattice edge sequencer: streams the edge list of an L x L square lattice,
// one edge per request transaction. Each request carries a restart bit (1 =
// start over at the first edge, 0 = next edge) and yields exactly one result
// transaction holding src_node, dst_node, valid_res and last. The order is the
// left/up edges of every interior node row by row, then the first-row and
// first-column edges, then (cyclic=1 and L>2) the row/column wrap edges; with
// directed=1 each edge is followed by its reverse. Past the final edge results
// come back all zero until a restart. Node ids are row*L+col, built from a
// running row base so no multiplier is needed. Throughput is one transaction
// per clock while out_ch is not stalled: a request enters an input register,
// the walk datapath forms the edge combinationally and steps its counters,
// and the edge lands in the output register, which drives out_ch (two
// register stages). While a result waits on a stalled output, the input
// register can take one more request; after that the request channel stalls
// until the result is taken.
// Config: cfg_we writes cfg_data into register cfg_index (0 side_len, clamped
// to 2..256; 1 cyclic; 2 directed); any valid write also restarts the walk.
// Writes must be made only while no transaction is in flight; not enforced.
// Depends on lseq_pkg, lseq_in_if, lseq_out_if, lseq_cfg and lseq_walk.
module lattice_edge_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  lseq_in_if.sink                         in_ch,
  lseq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lseq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lseq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lseq_pkg::*;

  cfg_t cfg, cfg_nxt;
  logic walk_clr;

  // input register stage
  logic s0_valid_r;
  logic s0_restart_r;

  // output register stage
  logic out_valid_r;
  res_t out_res_r;
  res_t walk_res;

  logic out_take;  // output register can load this cycle
  logic step;      // request moves from input reg through the walk

  assign out_take    = !out_valid_r || out_ch.ready;
  assign step        = s0_valid_r && out_take;
  assign in_ch.ready = !s0_valid_r || step;

  lseq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_nxt   (cfg_nxt),
    .walk_clr  (walk_clr)
  );

  lseq_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cfg_nxt  (cfg_nxt),
    .walk_clr (walk_clr),
    .step     (step),
    .restart  (s0_restart_r),
    .res      (walk_res)
  );

  // control valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (out_take) begin
        out_valid_r <= s0_valid_r;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_restart_r <= in_ch.restart;
    end
    if (step) begin
      out_res_r <= walk_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.src_node  = out_res_r.src_node;
  assign out_ch.dst_node  = out_res_r.dst_node;
  assign out_ch.valid_res = out_res_r.valid_res;
  assign out_ch.last      = out_res_r.last;

endmodule
